// ----- rtl/psrv_pkg.sv -----
`default_nettype none
package psrv_pkg;

    localparam int MAX_SPAN_DEF   = 64;
    localparam int PHASE_BITS_DEF = 16;

    localparam int WIN_W   = 7;
    localparam int WL_W    = 20;
    localparam int TICK_W  = 36;
    localparam int TS_W    = 32;
    localparam int QUOT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;

    localparam logic [WIN_W-1:0]  WINDOW_LEN_RST = 7'd8;
    localparam logic [WL_W-1:0]   WAVELENGTH_RST = 20'd46000;
    localparam logic [TICK_W-1:0] TICK_HZ_RST    = 36'd32768;
    localparam logic [TS_W-1:0]   MIN_SPAN_RST   = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN = 2'd0,
        REG_WAVELENGTH = 2'd1,
        REG_TICK_HZ    = 2'd2,
        REG_MIN_SPAN   = 2'd3
    } t_cfg_reg;

    localparam logic [1:0] ST_VALID      = 2'd0;
    localparam logic [1:0] ST_NOT_FILLED = 2'd1;
    localparam logic [1:0] ST_SPAN_SMALL = 2'd2;

    typedef struct packed {
        logic [15:0]     phase;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] velocity_um_s;
        logic [TS_W-1:0]    span_ticks;
    } t_out_item;

    typedef struct packed {
        logic take_in;
        logic upd;
        logic abs_en;
        logic mul_a;
        logic mul_lo;
        logic mul_hi;
        logic prep;
        logic div_step;
        logic load_out;
    } t_psrv_cmd;

    typedef struct packed {
        logic filled;
        logic span_bad;
        logic sat;
        logic div_done;
    } t_psrv_sts;

endpackage
`default_nettype wire

// ----- rtl/psrv_ram.sv -----
`default_nettype none
module psrv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/psrv_ctrl.sv -----
`default_nettype none
module psrv_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire psrv_pkg::t_psrv_sts i_sts,
    output psrv_pkg::t_psrv_cmd      o_cmd
);
    import psrv_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RD    = 11'b000_0000_0010,
        S_UPD   = 11'b000_0000_0100,
        S_CHK   = 11'b000_0000_1000,
        S_ABS   = 11'b000_0001_0000,
        S_MULA  = 11'b000_0010_0000,
        S_MULLO = 11'b000_0100_0000,
        S_MULHI = 11'b000_1000_0000,
        S_PREP  = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                // short path when no velocity is due
                if (!i_sts.filled || i_sts.span_bad) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MULLO;
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // skip the quotient when it saturates anyway
                if (i_sts.sat) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_done) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/psrv_dp.sv -----
`default_nettype none
module psrv_dp #(
    parameter int MAX_SPAN   = psrv_pkg::MAX_SPAN_DEF,
    parameter int PHASE_BITS = psrv_pkg::PHASE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [psrv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [psrv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire psrv_pkg::t_in_item                i_in_data,
    input  wire psrv_pkg::t_psrv_cmd               i_cmd,
    output psrv_pkg::t_psrv_sts                    o_sts,
    output psrv_pkg::t_out_item                    o_out_data
);
    import psrv_pkg::*;

    localparam int AW     = $clog2(MAX_SPAN);
    localparam int FILL_W = $clog2(MAX_SPAN + 1);
    localparam int CMP_W  = (FILL_W > WIN_W) ? FILL_W : WIN_W;
    localparam int OW     = FILL_W + 1;
    localparam int SUM_W  = PHASE_BITS + AW + 1;
    localparam int A_W    = SUM_W + WL_W;
    localparam int PROD_W = A_W + TICK_W;
    localparam int SHIFT  = PHASE_BITS + 1;
    localparam int NUM_W  = PROD_W - SHIFT;
    localparam int HI_W   = NUM_W - QUOT_W;
    localparam int SC_W   = (HI_W > TS_W) ? HI_W : TS_W;
    localparam int TLO_W  = TICK_W / 2;
    localparam int THI_W  = TICK_W - TLO_W;
    localparam int DCNT_W = $clog2(QUOT_W);

    // configuration
    logic [WIN_W-1:0]  r_window_len;
    logic [WL_W-1:0]   r_wavelength;
    logic [TICK_W-1:0] r_tick_hz;
    logic [TS_W-1:0]   r_min_span;

    // sample state
    logic [PHASE_BITS-1:0] r_ph, r_last;
    logic [TS_W-1:0]       r_ts;
    logic [AW-1:0]         r_head, r_old;
    logic [FILL_W-1:0]     r_fill;
    logic signed [SUM_W-1:0] r_sum;

    // result path
    logic              r_filled, r_span_bad, r_neg_v, r_sat;
    logic [TS_W-1:0]   r_span;
    logic [SUM_W-1:0]  r_mag;
    logic [A_W-1:0]    r_a;
    logic [PROD_W-1:0] r_acc;
    logic [TS_W:0]     r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [DCNT_W-1:0] r_div_cnt;

    // ring ports
    logic [PHASE_BITS-1:0] diff_rdata, d_new;
    logic [TS_W-1:0]       time_rdata;

    psrv_ram #(.WIDTH(PHASE_BITS), .DEPTH(MAX_SPAN)) u_diff_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_head),
        .i_wdata (d_new),
        .i_raddr (r_old),
        .o_rdata (diff_rdata)
    );

    psrv_ram #(.WIDTH(TS_W), .DEPTH(MAX_SPAN)) u_time_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_head),
        .i_wdata (r_ts),
        .i_raddr (r_old),
        .o_rdata (time_rdata)
    );

    // effective window, clamped
    logic [CMP_W-1:0]  win_ext, win_eff;
    logic [FILL_W-1:0] w;
    always_comb begin
        win_ext = CMP_W'(r_window_len);
        if (win_ext < CMP_W'(2)) begin
            win_eff = CMP_W'(2);
        end else if (win_ext > CMP_W'(MAX_SPAN)) begin
            win_eff = CMP_W'(MAX_SPAN);
        end else begin
            win_eff = win_ext;
        end
        w = FILL_W'(win_eff);
    end

    // oldest slot of the window
    logic [OW-1:0] head_ext, w_m1, old_sum;
    assign head_ext = OW'(r_head);
    assign w_m1     = OW'(w) - OW'(1);
    assign old_sum  = (head_ext >= w_m1) ? (head_ext - w_m1)
                                         : (head_ext + OW'(MAX_SPAN) - w_m1);

    logic [PHASE_BITS+15:0] ph_in_ext;
    assign ph_in_ext = {{PHASE_BITS{1'b0}}, i_in_data.phase};

    logic full_before, has_prev;
    assign full_before = (r_fill >= w);
    assign has_prev    = (r_fill != '0);
    assign d_new       = has_prev ? (r_ph - r_last) : '0;

    logic signed [SUM_W-1:0] sx_old, sx_new, sum_upd;
    logic [FILL_W-1:0]       fill_upd;
    logic [TS_W-1:0]         span_upd;
    assign sx_old   = {{(SUM_W-PHASE_BITS){diff_rdata[PHASE_BITS-1]}}, diff_rdata};
    assign sx_new   = {{(SUM_W-PHASE_BITS){d_new[PHASE_BITS-1]}}, d_new};
    assign sum_upd  = r_sum - (full_before ? sx_old : '0) + sx_new;
    assign fill_upd = full_before ? r_fill : (r_fill + FILL_W'(1));
    assign span_upd = r_ts - time_rdata;

    // product terms
    logic [A_W-1:0]         a_prod;
    logic [A_W+TLO_W-1:0]   lo_prod;
    logic [A_W+THI_W-1:0]   hi_prod;
    assign a_prod  = {{WL_W{1'b0}}, r_mag} * {{SUM_W{1'b0}}, r_wavelength};
    assign lo_prod = {{TLO_W{1'b0}}, r_a} * {{A_W{1'b0}}, r_tick_hz[TLO_W-1:0]};
    assign hi_prod = {{THI_W{1'b0}}, r_a} * {{A_W{1'b0}}, r_tick_hz[TICK_W-1:TLO_W]};

    // divide by span << SHIFT: drop the low SHIFT bits, then divide by span
    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  num_hi;
    assign num    = r_acc[PROD_W-1:SHIFT];
    assign num_hi = num[NUM_W-1:QUOT_W];

    logic [TS_W:0] rem_sh, rem_sub;
    logic          q_bit;
    assign rem_sh  = {r_rem[TS_W-1:0], r_q[QUOT_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_span});
    assign rem_sub = q_bit ? (rem_sh - {1'b0, r_span}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RST;
            r_wavelength <= WAVELENGTH_RST;
            r_tick_hz    <= TICK_HZ_RST;
            r_min_span   <= MIN_SPAN_RST;
            r_last       <= '0;
            r_head       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_WINDOW_LEN: begin
                        r_window_len <= i_cfg_data[WIN_W-1:0];
                        // empty the window
                        r_fill       <= '0;
                        r_sum        <= '0;
                    end
                    REG_WAVELENGTH: r_wavelength <= i_cfg_data[WL_W-1:0];
                    REG_TICK_HZ:    r_tick_hz    <= i_cfg_data[TICK_W-1:0];
                    REG_MIN_SPAN:   r_min_span   <= i_cfg_data[TS_W-1:0];
                    default: ;
                endcase
            end else if (i_cmd.upd) begin
                r_sum  <= sum_upd;
                r_fill <= fill_upd;
                r_last <= r_ph;
                r_head <= (r_head == AW'(MAX_SPAN - 1)) ? '0 : (r_head + AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_ph  <= ph_in_ext[PHASE_BITS-1:0];
            r_ts  <= i_in_data.timestamp;
            r_old <= old_sum[AW-1:0];
        end
        if (i_cmd.upd) begin
            r_filled   <= (fill_upd >= w);
            r_span     <= span_upd;
            r_span_bad <= (span_upd == '0) || (span_upd < r_min_span);
        end
        if (i_cmd.abs_en) begin
            r_mag   <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_neg_v <= !r_sum[SUM_W-1] && (r_sum != '0);
        end
        if (i_cmd.mul_a) begin
            r_a <= a_prod;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= PROD_W'(lo_prod);
        end
        if (i_cmd.mul_hi) begin
            r_acc <= r_acc + {hi_prod, {TLO_W{1'b0}}};
        end
        if (i_cmd.prep) begin
            r_sat     <= (SC_W'(num_hi) >= SC_W'(r_span));
            r_rem     <= {1'b0, TS_W'(num_hi)};
            r_q       <= num[QUOT_W-1:0];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_sub;
            r_q       <= {r_q[QUOT_W-2:0], q_bit};
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    assign o_sts.filled   = r_filled;
    assign o_sts.span_bad = r_span_bad;
    assign o_sts.sat      = r_sat;
    assign o_sts.div_done = (r_div_cnt == DCNT_W'(QUOT_W - 1));

    // result formatting
    logic [QUOT_W-1:0] lim, v_mag;
    t_out_item         res;
    always_comb begin
        lim   = r_neg_v ? 32'h8000_0000 : 32'h7FFF_FFFF;
        v_mag = (r_sat || (r_q > lim)) ? lim : r_q;
        res   = '0;
        if (!r_filled) begin
            res.status = ST_NOT_FILLED;
        end else if (r_span_bad) begin
            res.status     = ST_SPAN_SMALL;
            res.span_ticks = r_span;
        end else begin
            res.status        = ST_VALID;
            res.span_ticks    = r_span;
            res.velocity_um_s = r_neg_v ? $signed(-v_mag) : $signed(v_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data <= res;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/phase_slope_radial_velocity_core.sv -----
// Phase-slope radial velocity core.
// Input channel (i_in_valid / o_in_ready, i_in_data) takes one sample per
// transaction: a binary-angle carrier phase and a tick timestamp. Output
// channel (o_out_valid / i_out_ready, o_out_data) returns one result per
// sample: status, velocity in um/s and the tick span of the window.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// writing the window length empties the window.
// A sample whose window is still filling or whose span is too small
// skips the arithmetic; when a velocity is computed, three multiply
// steps run and then a 32-step restoring divider, which a saturating
// quotient skips. One sample is in work at a time; the next can be
// taken in the cycle after its result is registered.
// Reset (synchronous, active low) restores the register defaults and
// empties the window; the sample rings need no clearing. A stalled
// receiver holds the result in the output register; the core accepts the
// next sample meanwhile and waits with its own result until the register
// frees.
`default_nettype none
module phase_slope_radial_velocity_core #(
    parameter int MAX_SPAN   = psrv_pkg::MAX_SPAN_DEF,
    parameter int PHASE_BITS = psrv_pkg::PHASE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [psrv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [psrv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire psrv_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output psrv_pkg::t_out_item                  o_out_data
);
    import psrv_pkg::*;

    t_psrv_cmd cmd;
    t_psrv_sts sts;

    psrv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    psrv_dp #(
        .MAX_SPAN   (MAX_SPAN),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psrv_pkg::*;

    localparam int RING_DEPTH = MAX_SPAN_DEF;
    localparam int ANGLE_BITS = PHASE_BITS_DEF;

    typedef enum int {
        PACE_STEADY,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    logic i_clk;
    logic rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    t_cfg_reg              cfg_idx  = REG_WINDOW_LEN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_taken  = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_fail        = 0;

    t_in_item  samples_waiting[$];
    t_out_item velocity_due[$];

    // predictor state
    logic [WIN_W-1:0]  win_reg;
    logic [WL_W-1:0]   wl_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TS_W-1:0]   min_span_reg;
    logic [15:0]       diff_hist[RING_DEPTH];
    logic [TS_W-1:0]   stamp_hist[RING_DEPTH];
    longint            turn_sum;
    logic [15:0]       prev_phase;
    int                samples_held;
    int                head_slot;

    phase_slope_radial_velocity_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void reset_predictor();
        win_reg      = WINDOW_LEN_RST;
        wl_reg       = WAVELENGTH_RST;
        tick_reg     = TICK_HZ_RST;
        min_span_reg = MIN_SPAN_RST;
        turn_sum     = 0;
        prev_phase   = '0;
        samples_held = 0;
        head_slot    = 0;
    endfunction

    function automatic void apply_reg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_WINDOW_LEN: begin
                // a new window length empties the window
                win_reg      = val[WIN_W-1:0];
                samples_held = 0;
                turn_sum     = 0;
            end
            REG_WAVELENGTH: wl_reg = val[WL_W-1:0];
            REG_TICK_HZ:    tick_reg = val[TICK_W-1:0];
            REG_MIN_SPAN:   min_span_reg = val[TS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_out_item predict_velocity(t_in_item s);
        t_out_item    r;
        int           w;
        int           slot;
        int           oldest;
        logic [15:0]  step;
        logic [31:0]  span;
        longint       mag;
        logic         neg_v;
        logic [127:0] num;
        logic [127:0] quot;
        logic [127:0] lim;
        w = (win_reg < 2) ? 2 : (win_reg > RING_DEPTH) ? RING_DEPTH : int'(win_reg);
        slot = head_slot;
        oldest = (slot + RING_DEPTH - (w - 1)) % RING_DEPTH;
        step = '0;
        // drop the difference that leaves the window, add the new one
        if (samples_held >= w)
            turn_sum -= longint'($signed(diff_hist[oldest]));
        if (samples_held >= 1) begin
            step = s.phase - prev_phase;
            turn_sum += longint'($signed(step));
        end
        diff_hist[slot]  = step;
        stamp_hist[slot] = s.timestamp;
        prev_phase       = s.phase;
        if (samples_held < w)
            samples_held++;
        head_slot = (slot + 1) % RING_DEPTH;

        r.status        = ST_NOT_FILLED;
        r.velocity_um_s = '0;
        r.span_ticks    = '0;
        if (samples_held < w)
            return r;

        span = s.timestamp - stamp_hist[oldest];
        r.span_ticks = span;
        if (span == 0 || span < min_span_reg) begin
            r.status = ST_SPAN_SMALL;
            return r;
        end
        mag   = (turn_sum < 0) ? -turn_sum : turn_sum;
        neg_v = (turn_sum > 0);
        num   = 128'(mag) * 128'(wl_reg) * 128'(tick_reg);
        quot  = num / ({96'd0, span} << (ANGLE_BITS + 1));
        lim   = neg_v ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quot > lim)
            quot = lim;
        r.status        = ST_VALID;
        r.velocity_um_s = neg_v ? -quot[31:0] : quot[31:0];
        return r;
    endfunction

    // driver: change inputs on the falling edge
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (!in_valid || in_taken) begin
                if (samples_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= samples_waiting.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results, then predict the newly accepted sample
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            reset_predictor();
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (velocity_due.size() == 0) begin
                    $error("unexpected transaction: status %0d span %0d",
                           o_out_data.status, o_out_data.span_ticks);
                    n_fail++;
                end else begin
                    want = velocity_due.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        n_fail++;
                    end
                    if (o_out_data.velocity_um_s !== want.velocity_um_s) begin
                        $error("velocity_um_s: expected %0d, got %0d",
                               want.velocity_um_s, o_out_data.velocity_um_s);
                        n_fail++;
                    end
                    if (o_out_data.span_ticks !== want.span_ticks) begin
                        $error("span_ticks: expected %0d, got %0d",
                               want.span_ticks, o_out_data.span_ticks);
                        n_fail++;
                    end
                end
            end
            if (cfg_we)
                apply_reg_write(cfg_idx, cfg_data);
            in_taken <= in_valid && o_in_ready;
            if (in_valid && o_in_ready)
                velocity_due.push_back(predict_velocity(in_data));
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every sample is taken and every result has come back
    task automatic drain();
        while (samples_waiting.size() != 0 || in_valid || velocity_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_STEADY:      begin send_idle_pct = 0;  stall_pct = 0;  end
            PACE_SEND_GAPS:   begin send_idle_pct = 75; stall_pct = 0;  end
            PACE_RECV_STALLS: begin send_idle_pct = 0;  stall_pct = 75; end
            default:          begin send_idle_pct = 27; stall_pct = 27; end
        endcase
    endtask

    // mostly steady tracks (slope plus jitter, advancing timestamps), some raw noise
    task automatic add_samples(input int count);
        t_in_item    s;
        logic [15:0] track_phase;
        logic [15:0] slope;
        logic [31:0] track_stamp;
        logic [31:0] step_max;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                track_phase = 16'($urandom);
                track_stamp = $urandom;
                slope       = 16'($urandom_range(2048)) - 16'd1024;
                if ($urandom_range(4) == 0)
                    slope = 16'($urandom);
                step_max = 32'd1 << $urandom_range(20);
            end
            if ($urandom_range(5) == 0) begin
                s.phase     = 16'($urandom);
                s.timestamp = $urandom;
            end else begin
                track_phase = track_phase + slope + 16'($urandom_range(64)) - 16'd32;
                track_stamp = track_stamp + $urandom_range(step_max);
                s.phase     = track_phase;
                s.timestamp = track_stamp;
            end
            samples_waiting.push_back(s);
        end
    endtask

    task automatic run_phase(input t_pace pace, input logic [CFG_DATA_W-1:0] win, wl,
                             tick, min_span, input int count);
        set_pace(pace);
        write_reg(REG_WINDOW_LEN, win);
        write_reg(REG_WAVELENGTH, wl);
        write_reg(REG_TICK_HZ, tick);
        write_reg(REG_MIN_SPAN, min_span);
        add_samples(count);
        drain();
    endtask

    // directed samples on the reset settings (window of 8)
    logic [15:0] dir_phase[24] = '{
        16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
        16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600, 16'h0700, 16'h0800,
        16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000
    };
    logic [31:0] dir_stamp[24] = '{
        32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0000, 32'h0000_0010,
        32'h0000_0020, 32'h0000_0030, 32'h0000_0040, 32'h0000_0050,
        32'h0000_0050, 32'h0000_0050, 32'h0000_0050, 32'h0000_0050,
        32'h0000_0050, 32'h0000_0050, 32'h0000_0050, 32'h0000_0050,
        32'h0000_004F, 32'h0000_0060, 32'h0000_0070, 32'h0000_0080,
        32'h0000_0090, 32'h0000_00A0, 32'h0000_00B0, 32'h0000_00C0
    };

    initial begin
        t_in_item s;
        reset_predictor();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        set_pace(PACE_STEADY);
        for (int k = 0; k < 24; k++) begin
            s.phase     = dir_phase[k];
            s.timestamp = dir_stamp[k];
            samples_waiting.push_back(s);
        end
        add_samples(100);
        drain();

        run_phase(PACE_SEND_GAPS, 36'd2, 36'hF_FFFF, 36'hF_FFFF_FFFF, 36'd0, 118);
        run_phase(PACE_RECV_STALLS, 36'd64, 36'd1, 36'd1, 36'hFFFF_FFFF, 118);
        run_phase(PACE_BOTH, 36'd0, 36'd0, 36'h8_0000_0001, 36'd1, 118);
        run_phase(PACE_STEADY, 36'd127, 36'd46000, 36'h1_0000_0000, 36'd1, 118);
        run_phase(PACE_SEND_GAPS, 36'd1, 36'($urandom_range(1000000, 1)),
                  {4'($urandom_range(15)), 32'($urandom)}, 36'd2, 118);
        run_phase(PACE_RECV_STALLS, 36'($urandom_range(64, 2)),
                  36'($urandom_range(1000000, 1)),
                  {4'($urandom_range(15)), 32'($urandom)},
                  36'($urandom_range(16, 1)), 118);
        run_phase(PACE_BOTH, 36'($urandom_range(64, 2)), 36'($urandom_range(1000000, 1)),
                  36'($urandom_range(100000, 1)), 36'($urandom_range(64, 1)), 118);

        repeat (50) @(posedge i_clk);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // the timeout lies well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
